// ===== hw/rtl/tafp_pkg.sv =====
// Package for the torsion angle block: field widths, item types, and the
// arctangent table used by the CORDIC cells.
// No dependencies.
`default_nettype none

package tafp_pkg;

  // Input coordinates and the vector arithmetic in front of the CORDIC.
  localparam int CoordW       = 24;
  localparam int DiffW        = CoordW + 1;
  localparam int ProdW        = 2 * DiffW;
  localparam int NormW        = ProdW + 1;
  localparam int SqW          = ProdW + 2;
  localparam int SplitW       = 26;
  localparam int MulW         = SplitW + 1;
  localparam int PpW          = 2 * MulW;
  localparam int XDotW        = 104;
  localparam int YDotW        = 78;
  localparam int SqrtGuard    = 16;
  localparam int RadW         = SqW + 2 * SqrtGuard;
  localparam int RootW        = RadW / 2;
  localparam int RootHalf     = RootW / 2;
  localparam int RemW         = RootW + 3;
  localparam int SqrtStages   = RootW;
  localparam int WideW        = 120;

  // Pipeline depths.
  localparam int FrontDly     = SqrtStages - 3;
  localparam int FrontLat     = SqrtStages + 5;
  localparam int NormLat      = 5;

  // Normalization and CORDIC.
  localparam int ChunkW       = 8;
  localparam int ChunkLog     = 3;
  localparam int ChunkN       = WideW / ChunkW;
  localparam int ChunkIdxW    = 4;
  localparam int LenW         = 7;
  localparam int CordicInBits = 30;
  localparam int CordicW      = CordicInBits + 4;
  localparam int CordicStages = 18;
  localparam int ShW          = 5;
  localparam int AngleFrac    = 15;
  localparam int TorsionW     = AngleFrac + 3;
  localparam int ZW           = TorsionW + 2;

  // Angles as Q32 fractions of a radian.
  localparam logic [63:0] AtanQ32 [32] = '{
    64'd3373259426, 64'd1991351318, 64'd1052175346, 64'd534100635, 64'd268086748,
    64'd134174063, 64'd67103403, 64'd33553749, 64'd16777131, 64'd8388597,
    64'd4194303, 64'd2097152, 64'd1048576, 64'd524288, 64'd262144, 64'd131072,
    64'd65536, 64'd32768, 64'd16384, 64'd8192, 64'd4096, 64'd2048, 64'd1024,
    64'd512, 64'd256, 64'd128, 64'd64, 64'd32, 64'd16, 64'd8, 64'd4, 64'd2
  };
  localparam logic [63:0] PiQ32     = 64'd13493037705;
  localparam logic [63:0] HalfPiQ32 = 64'd6746518852;

  // Input item: four points.
  typedef struct packed {
    logic signed [CoordW-1:0] p1_x;
    logic signed [CoordW-1:0] p1_y;
    logic signed [CoordW-1:0] p1_z;
    logic signed [CoordW-1:0] p2_x;
    logic signed [CoordW-1:0] p2_y;
    logic signed [CoordW-1:0] p2_z;
    logic signed [CoordW-1:0] p3_x;
    logic signed [CoordW-1:0] p3_y;
    logic signed [CoordW-1:0] p3_z;
    logic signed [CoordW-1:0] p4_x;
    logic signed [CoordW-1:0] p4_y;
    logic signed [CoordW-1:0] p4_z;
  } tafp_in_t;

  // Result item.
  typedef struct packed {
    logic signed [TorsionW-1:0] torsion;
    logic                       degenerate;
  } tafp_res_t;

  // Full-width (y, x) pair leaving the vector front end.
  typedef struct packed {
    logic                    vld;
    logic                    deg;
    logic signed [WideW-1:0] x;
    logic signed [WideW-1:0] y;
  } tafp_vec_t;

  // State carried from one CORDIC cell to the next.
  typedef struct packed {
    logic                      vld;
    logic                      deg;
    logic signed [CordicW-1:0] x;
    logic signed [CordicW-1:0] y;
    logic signed [ZW-1:0]      z;
  } tafp_rot_t;

  // State carried from one square-root cell to the next.
  typedef struct packed {
    logic [RadW-1:0]  rad;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } tafp_sqrt_t;

  // Rounds a Q32 angle half up to the output fraction.
  function automatic logic signed [ZW-1:0] q32_to_angle(input logic [63:0] v);
    logic [63:0] r;
    r = (v + (64'd1 << (31 - AngleFrac))) >> (32 - AngleFrac);
    return $signed(r[ZW-1:0]);
  endfunction

  function automatic logic signed [ZW-1:0] atan_angle(input int i);
    return q32_to_angle(AtanQ32[i]);
  endfunction

  localparam logic signed [ZW-1:0] PiAngle     = q32_to_angle(PiQ32);
  localparam logic signed [ZW-1:0] HalfPiAngle = q32_to_angle(HalfPiQ32);

  // One partial product of split operands.
  function automatic logic signed [PpW-1:0] smul(input logic signed [MulW-1:0] a,
                                                 input logic signed [MulW-1:0] b);
    return PpW'(a) * PpW'(b);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/torsion_angle_from_four_points.sv =====
// Top level of the torsion angle block: front end, normalization, CORDIC
// chain and result register. Depends on tafp_pkg and all tafp_* modules.
`default_nettype none

// Usage: the block takes one item in every cycle and never raises busy_o.
// Each item's result appears on res_o with done_o high for one cycle, in the
// order the items came in. Each item passes through the front end, with its
// 42-cell square-root chain for |b2|, then normalization, 18 CORDIC cells and
// the result register. The receiver cannot stall the block, so it must take
// every result in the cycle it is shown.
module torsion_angle_from_four_points (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  tafp_pkg::tafp_in_t  pts_i,
  output logic                busy_o,
  output logic                done_o,
  output tafp_pkg::tafp_res_t res_o
);

  logic                 accept;
  tafp_pkg::tafp_vec_t  vec;
  tafp_pkg::tafp_rot_t  rot [tafp_pkg::CordicStages+1];
  tafp_pkg::tafp_rot_t  fin;
  logic                 done_q;
  tafp_pkg::tafp_res_t  res_d, res_q;

  // The pipeline advances every cycle.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  tafp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (accept),
    .pts_i  (pts_i),
    .vec_o  (vec)
  );

  tafp_norm u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vec_i  (vec),
    .rot_o  (rot[0])
  );

  // Chain of CORDIC cells.
  for (genvar k = 0; k < tafp_pkg::CordicStages; k++) begin : g_cordic
    tafp_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cell_i  (rot[k]),
      .shift_i (tafp_pkg::ShW'(k)),
      .atan_i  (tafp_pkg::atan_angle(k)),
      .cell_o  (rot[k+1])
    );
  end

  assign fin = rot[tafp_pkg::CordicStages];

  // Clamp to [-pi, pi]; a degenerate item gives angle zero.
  always_comb begin
    res_d.degenerate = fin.deg;
    if (fin.deg) begin
      res_d.torsion = '0;
    end else if (fin.z > tafp_pkg::PiAngle) begin
      res_d.torsion = tafp_pkg::TorsionW'(tafp_pkg::PiAngle);
    end else if (fin.z < -tafp_pkg::PiAngle) begin
      res_d.torsion = tafp_pkg::TorsionW'(-tafp_pkg::PiAngle);
    end else begin
      res_d.torsion = tafp_pkg::TorsionW'(fin.z);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= fin.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // A degenerate result carries angle zero.
  a_deg_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.degenerate |-> res_o.torsion == '0)
    else $error("degenerate item with nonzero angle");

  // Results stay within [-pi, pi].
  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (tafp_pkg::ZW'(res_o.torsion) <= tafp_pkg::PiAngle)
            && (tafp_pkg::ZW'(res_o.torsion) >= -tafp_pkg::PiAngle))
    else $error("angle outside [-pi, pi]");

  // After the pre-rotation the vector lies in the right half plane.
  a_prerot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rot[0].vld |-> !rot[0].x[tafp_pkg::CordicW-1])
    else $error("CORDIC input with negative x");

endmodule

`default_nettype wire

// ===== hw/rtl/tafp_sqrt_cell.sv =====
// One cell of the integer square-root chain: resolves one root bit per cycle.
// Depends on tafp_pkg.
`default_nettype none

module tafp_sqrt_cell (
  input  logic                  clk_i,
  input  tafp_pkg::tafp_sqrt_t  cell_i,
  output tafp_pkg::tafp_sqrt_t  cell_o
);

  logic [tafp_pkg::RemW-1:0] rem_sh;
  logic [tafp_pkg::RemW-1:0] trial;
  tafp_pkg::tafp_sqrt_t      cell_d;
  tafp_pkg::tafp_sqrt_t      cell_q;

  // Bring down the next two radicand bits and try a one for this root bit.
  always_comb begin
    rem_sh = {cell_i.rem[tafp_pkg::RemW-3:0], cell_i.rad[tafp_pkg::RadW-1 -: 2]};
    trial  = tafp_pkg::RemW'({cell_i.root, 2'b01});
    cell_d.rad = {cell_i.rad[tafp_pkg::RadW-3:0], 2'b00};
    if (rem_sh >= trial) begin
      cell_d.rem  = rem_sh - trial;
      cell_d.root = {cell_i.root[tafp_pkg::RootW-2:0], 1'b1};
    end else begin
      cell_d.rem  = rem_sh;
      cell_d.root = {cell_i.root[tafp_pkg::RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tafp_front.sv =====
// Vector front end: bond vectors, normals, dot products, |b2| through a
// chain of square-root cells, and the scaled (y, x) pair.
// Depends on tafp_pkg and tafp_sqrt_cell.
`default_nettype none

module tafp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 vld_i,
  input  tafp_pkg::tafp_in_t   pts_i,
  output tafp_pkg::tafp_vec_t  vec_o
);

  localparam int Lat = tafp_pkg::FrontLat;
  localparam int Dly = tafp_pkg::FrontDly;

  logic [Lat-1:0]                        vld_q;
  logic [Lat-4:0]                        degp_q;
  logic signed [tafp_pkg::DiffW-1:0]     b1_q [3];
  logic signed [tafp_pkg::DiffW-1:0]     b2_q [3];
  logic signed [tafp_pkg::DiffW-1:0]     b3_q [3];
  logic signed [tafp_pkg::DiffW-1:0]     b1s2_q [3];
  logic signed [tafp_pkg::DiffW-1:0]     b1s3_q [3];
  logic signed [tafp_pkg::ProdW-1:0]     pa_q [3];
  logic signed [tafp_pkg::ProdW-1:0]     pb_q [3];
  logic signed [tafp_pkg::ProdW-1:0]     qa_q [3];
  logic signed [tafp_pkg::ProdW-1:0]     qb_q [3];
  logic signed [tafp_pkg::ProdW-1:0]     sq_q [3];
  logic                                  b2z_q;
  logic signed [tafp_pkg::NormW-1:0]     n1_d [3];
  logic signed [tafp_pkg::NormW-1:0]     n2_d [3];
  logic signed [tafp_pkg::NormW-1:0]     n1_q [3];
  logic signed [tafp_pkg::NormW-1:0]     n2_q [3];
  logic [tafp_pkg::SqW-1:0]              b2sq_q;
  logic                                  deg3_q;
  logic signed [tafp_pkg::PpW-1:0]       xpp_q [3][4];
  logic signed [tafp_pkg::PpW-1:0]       ypp_q [3][2];
  logic signed [tafp_pkg::XDotW-1:0]     xterm_q [3];
  logic signed [tafp_pkg::YDotW-1:0]     yterm_q [3];
  logic signed [tafp_pkg::XDotW-1:0]     xdot_q;
  logic signed [tafp_pkg::YDotW-1:0]     ydot_q;
  logic signed [tafp_pkg::XDotW-1:0]     xdl_q [Dly];
  logic signed [tafp_pkg::YDotW-1:0]     ydl_q [Dly];
  tafp_pkg::tafp_sqrt_t                  sq_chain [tafp_pkg::SqrtStages+1];
  logic signed [tafp_pkg::PpW-1:0]       yfp_q [3][2];
  logic signed [tafp_pkg::XDotW-1:0]     x46_q;
  logic signed [tafp_pkg::WideW-1:0]     x_d;
  logic signed [tafp_pkg::WideW-1:0]     y_d;
  logic signed [tafp_pkg::WideW-1:0]     x47_q;
  logic signed [tafp_pkg::WideW-1:0]     y47_q;
  logic signed [tafp_pkg::MulW-1:0]      yd_pc [3];
  logic signed [tafp_pkg::MulW-1:0]      rt_pc [2];
  logic [tafp_pkg::RootW-1:0]            root;
  logic signed [tafp_pkg::YDotW-1:0]     ydel;

  // Item valid and degenerate flags travel beside the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    degp_q <= {degp_q[Lat-5:0], deg3_q};
  end

  // Bond vectors.
  always_ff @(posedge clk_i) begin
    b1_q[0] <= tafp_pkg::DiffW'(pts_i.p2_x) - tafp_pkg::DiffW'(pts_i.p1_x);
    b1_q[1] <= tafp_pkg::DiffW'(pts_i.p2_y) - tafp_pkg::DiffW'(pts_i.p1_y);
    b1_q[2] <= tafp_pkg::DiffW'(pts_i.p2_z) - tafp_pkg::DiffW'(pts_i.p1_z);
    b2_q[0] <= tafp_pkg::DiffW'(pts_i.p3_x) - tafp_pkg::DiffW'(pts_i.p2_x);
    b2_q[1] <= tafp_pkg::DiffW'(pts_i.p3_y) - tafp_pkg::DiffW'(pts_i.p2_y);
    b2_q[2] <= tafp_pkg::DiffW'(pts_i.p3_z) - tafp_pkg::DiffW'(pts_i.p2_z);
    b3_q[0] <= tafp_pkg::DiffW'(pts_i.p4_x) - tafp_pkg::DiffW'(pts_i.p3_x);
    b3_q[1] <= tafp_pkg::DiffW'(pts_i.p4_y) - tafp_pkg::DiffW'(pts_i.p3_y);
    b3_q[2] <= tafp_pkg::DiffW'(pts_i.p4_z) - tafp_pkg::DiffW'(pts_i.p3_z);
  end

  // Cross-product terms and squares of the middle bond.
  for (genvar k = 0; k < 3; k++) begin : g_cross
    localparam int I1 = (k + 1) % 3;
    localparam int I2 = (k + 2) % 3;

    always_ff @(posedge clk_i) begin
      pa_q[k]   <= tafp_pkg::ProdW'(b1_q[I1]) * tafp_pkg::ProdW'(b2_q[I2]);
      pb_q[k]   <= tafp_pkg::ProdW'(b1_q[I2]) * tafp_pkg::ProdW'(b2_q[I1]);
      qa_q[k]   <= tafp_pkg::ProdW'(b2_q[I1]) * tafp_pkg::ProdW'(b3_q[I2]);
      qb_q[k]   <= tafp_pkg::ProdW'(b2_q[I2]) * tafp_pkg::ProdW'(b3_q[I1]);
      sq_q[k]   <= tafp_pkg::ProdW'(b2_q[k]) * tafp_pkg::ProdW'(b2_q[k]);
      b1s2_q[k] <= b1_q[k];
      b1s3_q[k] <= b1s2_q[k];
    end

    assign n1_d[k] = tafp_pkg::NormW'(pa_q[k]) - tafp_pkg::NormW'(pb_q[k]);
    assign n2_d[k] = tafp_pkg::NormW'(qa_q[k]) - tafp_pkg::NormW'(qb_q[k]);
  end

  // Normals, squared length of b2, and the degenerate test.
  always_ff @(posedge clk_i) begin
    b2z_q  <= (b2_q[0] == '0) && (b2_q[1] == '0) && (b2_q[2] == '0);
    n1_q   <= n1_d;
    n2_q   <= n2_d;
    b2sq_q <= tafp_pkg::SqW'($unsigned(sq_q[0])) + tafp_pkg::SqW'($unsigned(sq_q[1]))
            + tafp_pkg::SqW'($unsigned(sq_q[2]));
    deg3_q <= b2z_q
            || ((n1_d[0] == '0) && (n1_d[1] == '0) && (n1_d[2] == '0))
            || ((n2_d[0] == '0) && (n2_d[1] == '0) && (n2_d[2] == '0));
  end

  // Split products for n1.n2 and b1.n2.
  for (genvar k = 0; k < 3; k++) begin : g_dotpp
    logic signed [tafp_pkg::MulW-1:0] ah, al, bh, bl, c;

    assign ah = tafp_pkg::MulW'($signed(n1_q[k][tafp_pkg::NormW-1:tafp_pkg::SplitW]));
    assign al = $signed({1'b0, n1_q[k][tafp_pkg::SplitW-1:0]});
    assign bh = tafp_pkg::MulW'($signed(n2_q[k][tafp_pkg::NormW-1:tafp_pkg::SplitW]));
    assign bl = $signed({1'b0, n2_q[k][tafp_pkg::SplitW-1:0]});
    assign c  = tafp_pkg::MulW'(b1s3_q[k]);

    always_ff @(posedge clk_i) begin
      xpp_q[k][0] <= tafp_pkg::smul(ah, bh);
      xpp_q[k][1] <= tafp_pkg::smul(ah, bl);
      xpp_q[k][2] <= tafp_pkg::smul(al, bh);
      xpp_q[k][3] <= tafp_pkg::smul(al, bl);
      ypp_q[k][0] <= tafp_pkg::smul(c, bh);
      ypp_q[k][1] <= tafp_pkg::smul(c, bl);
      xterm_q[k]  <= (tafp_pkg::XDotW'(xpp_q[k][0]) <<< (2 * tafp_pkg::SplitW))
                   + ((tafp_pkg::XDotW'(xpp_q[k][1]) + tafp_pkg::XDotW'(xpp_q[k][2]))
                      <<< tafp_pkg::SplitW)
                   + tafp_pkg::XDotW'(xpp_q[k][3]);
      yterm_q[k]  <= (tafp_pkg::YDotW'(ypp_q[k][0]) <<< tafp_pkg::SplitW)
                   + tafp_pkg::YDotW'(ypp_q[k][1]);
    end
  end

  // Dot products, then held until the root of |b2| is ready.
  always_ff @(posedge clk_i) begin
    xdot_q <= xterm_q[0] + xterm_q[1] + xterm_q[2];
    ydot_q <= yterm_q[0] + yterm_q[1] + yterm_q[2];
    xdl_q[0] <= xdot_q;
    ydl_q[0] <= ydot_q;
    for (int j = 1; j < Dly; j++) begin
      xdl_q[j] <= xdl_q[j-1];
      ydl_q[j] <= ydl_q[j-1];
    end
  end

  // Square root of |b2|^2 with guard bits, one root bit per cell.
  assign sq_chain[0].rad  = tafp_pkg::RadW'(b2sq_q) << (2 * tafp_pkg::SqrtGuard);
  assign sq_chain[0].rem  = '0;
  assign sq_chain[0].root = '0;

  for (genvar s = 0; s < tafp_pkg::SqrtStages; s++) begin : g_sqrt
    tafp_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .cell_i (sq_chain[s]),
      .cell_o (sq_chain[s+1])
    );
  end

  // y = (b1 . n2) * |b2| as split products.
  assign root     = sq_chain[tafp_pkg::SqrtStages].root;
  assign ydel     = ydl_q[Dly-1];
  assign yd_pc[0] = $signed({1'b0, ydel[tafp_pkg::SplitW-1:0]});
  assign yd_pc[1] = $signed({1'b0, ydel[2*tafp_pkg::SplitW-1:tafp_pkg::SplitW]});
  assign yd_pc[2] = tafp_pkg::MulW'($signed(ydel[tafp_pkg::YDotW-1:2*tafp_pkg::SplitW]));
  assign rt_pc[0] = $signed(tafp_pkg::MulW'(root[tafp_pkg::RootHalf-1:0]));
  assign rt_pc[1] = $signed(tafp_pkg::MulW'(root[tafp_pkg::RootW-1:tafp_pkg::RootHalf]));

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 2; j++) begin
        yfp_q[k][j] <= tafp_pkg::smul(yd_pc[k], rt_pc[j]);
      end
    end
    x46_q <= xdl_q[Dly-1];
  end

  // Put x and y on one scale.
  always_comb begin
    y_d = '0;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 2; j++) begin
        y_d = y_d + (tafp_pkg::WideW'(yfp_q[k][j])
                     <<< (tafp_pkg::SplitW * k + tafp_pkg::RootHalf * j));
      end
    end
    x_d = tafp_pkg::WideW'(x46_q) <<< tafp_pkg::SqrtGuard;
  end

  always_ff @(posedge clk_i) begin
    x47_q <= x_d;
    y47_q <= y_d;
  end

  assign vec_o.vld = vld_q[Lat-1];
  assign vec_o.deg = degp_q[Lat-4];
  assign vec_o.x   = x47_q;
  assign vec_o.y   = y47_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tafp_norm.sv =====
// Scales the wide (y, x) pair down to CORDIC width and applies the
// quadrant pre-rotation. Depends on tafp_pkg.
`default_nettype none

module tafp_norm (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tafp_pkg::tafp_vec_t  vec_i,
  output tafp_pkg::tafp_rot_t  rot_o
);

  localparam int Lat = tafp_pkg::NormLat;

  logic [Lat-1:0]                      vld_q;
  logic [Lat-1:0]                      deg_q;
  logic [tafp_pkg::WideW-1:0]          ax1_q, ay1_q, ax2_q, ay2_q, ax3_q, ay3_q;
  logic [Lat-2:0]                      sx_q, sy_q;
  logic [tafp_pkg::WideW-1:0]          mag;
  logic [tafp_pkg::ChunkIdxW-1:0]      idx_d, idx_q;
  logic [tafp_pkg::ChunkW-1:0]         chk_d, chk_q;
  logic [tafp_pkg::ChunkLog:0]         bl;
  logic [tafp_pkg::LenW-1:0]           la, sh_d, sh_q;
  logic [tafp_pkg::WideW-1:0]          xsh, ysh;
  logic [tafp_pkg::CordicInBits-1:0]   xm_q, ym_q;
  logic signed [tafp_pkg::CordicW-1:0] xv, yv, x_d, y_d, x_q, y_q;
  logic signed [tafp_pkg::ZW-1:0]      z_d, z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], vec_i.vld};
    end
  end

  always_ff @(posedge clk_i) begin
    deg_q <= {deg_q[Lat-2:0], vec_i.deg};
    sx_q  <= {sx_q[Lat-3:0], vec_i.x[tafp_pkg::WideW-1]};
    sy_q  <= {sy_q[Lat-3:0], vec_i.y[tafp_pkg::WideW-1]};
  end

  // Magnitudes.
  always_ff @(posedge clk_i) begin
    ax1_q <= vec_i.x[tafp_pkg::WideW-1] ? $unsigned(-vec_i.x) : $unsigned(vec_i.x);
    ay1_q <= vec_i.y[tafp_pkg::WideW-1] ? $unsigned(-vec_i.y) : $unsigned(vec_i.y);
  end

  // Highest nonzero byte of the larger magnitude.
  always_comb begin
    mag   = ax1_q | ay1_q;
    idx_d = '0;
    chk_d = '0;
    for (int c = 0; c < tafp_pkg::ChunkN; c++) begin
      if (|mag[tafp_pkg::ChunkW*c +: tafp_pkg::ChunkW]) begin
        idx_d = tafp_pkg::ChunkIdxW'(c);
        chk_d = mag[tafp_pkg::ChunkW*c +: tafp_pkg::ChunkW];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    chk_q <= chk_d;
    ax2_q <= ax1_q;
    ay2_q <= ay1_q;
  end

  // Bit length and the right shift that leaves the CORDIC input width.
  always_comb begin
    bl = '0;
    for (int b = 0; b < tafp_pkg::ChunkW; b++) begin
      if (chk_q[b]) begin
        bl = (tafp_pkg::ChunkLog + 1)'(b + 1);
      end
    end
    la   = tafp_pkg::LenW'({idx_q, {tafp_pkg::ChunkLog{1'b0}}}) + tafp_pkg::LenW'(bl);
    sh_d = (la > tafp_pkg::LenW'(tafp_pkg::CordicInBits))
         ? la - tafp_pkg::LenW'(tafp_pkg::CordicInBits) : '0;
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    ax3_q <= ax2_q;
    ay3_q <= ay2_q;
  end

  // Shift both magnitudes by the same amount.
  assign xsh = ax3_q >> sh_q;
  assign ysh = ay3_q >> sh_q;

  always_ff @(posedge clk_i) begin
    xm_q <= xsh[tafp_pkg::CordicInBits-1:0];
    ym_q <= ysh[tafp_pkg::CordicInBits-1:0];
  end

  // Restore signs, then turn by 90 degrees when x is negative.
  always_comb begin
    xv = $signed(tafp_pkg::CordicW'(xm_q));
    yv = $signed(tafp_pkg::CordicW'(ym_q));
    if (sx_q[Lat-2]) begin
      xv = -xv;
    end
    if (sy_q[Lat-2]) begin
      yv = -yv;
    end
    x_d = xv;
    y_d = yv;
    z_d = '0;
    if (xv < 0) begin
      if (yv >= 0) begin
        x_d = yv;
        y_d = -xv;
        z_d = tafp_pkg::HalfPiAngle;
      end else begin
        x_d = -yv;
        y_d = xv;
        z_d = -tafp_pkg::HalfPiAngle;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign rot_o.vld = vld_q[Lat-1];
  assign rot_o.deg = deg_q[Lat-1];
  assign rot_o.x   = x_q;
  assign rot_o.y   = y_q;
  assign rot_o.z   = z_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tafp_cordic_cell.sv =====
// One vectoring CORDIC cell: a single micro-rotation per cycle.
// Depends on tafp_pkg.
`default_nettype none

module tafp_cordic_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tafp_pkg::tafp_rot_t            cell_i,
  input  logic [tafp_pkg::ShW-1:0]       shift_i,
  input  logic signed [tafp_pkg::ZW-1:0] atan_i,
  output tafp_pkg::tafp_rot_t            cell_o
);

  logic signed [tafp_pkg::CordicW-1:0] dx, dy, x_d, y_d, x_q, y_q;
  logic signed [tafp_pkg::ZW-1:0]      z_d, z_q;
  logic                                vld_q, deg_q;

  // Turn toward the x axis; shifts round toward minus infinity.
  always_comb begin
    dx = cell_i.y >>> shift_i;
    dy = cell_i.x >>> shift_i;
    if (!cell_i.y[tafp_pkg::CordicW-1]) begin
      x_d = cell_i.x + dx;
      y_d = cell_i.y - dy;
      z_d = cell_i.z + atan_i;
    end else begin
      x_d = cell_i.x - dx;
      y_d = cell_i.y + dy;
      z_d = cell_i.z - atan_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= cell_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    deg_q <= cell_i.deg;
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
  end

  assign cell_o.vld = vld_q;
  assign cell_o.deg = deg_q;
  assign cell_o.x   = x_q;
  assign cell_o.y   = y_q;
  assign cell_o.z   = z_q;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the torsion angle block: directed and random
// point sets, each result checked against an in-bench fixed-point predictor.
// Depends on tafp_pkg and torsion_angle_from_four_points.
`timescale 1ns / 100ps

module tb_top;

  typedef logic signed [255:0] wide_t;

  localparam int CycleLimit = 200000;
  localparam int RandItems  = 850;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  tafp_pkg::tafp_in_t  pts_i;
  logic                busy_o;
  logic                done_o;
  tafp_pkg::tafp_res_t res_o;

  tafp_pkg::tafp_res_t angle_q[$];
  int                  errors;
  int                  cycles;

  torsion_angle_from_four_points DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .pts_i(pts_i),
    .busy_o(busy_o), .done_o(done_o), .res_o(res_o)
  );

  // Clock with a 20 ns period.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("torsion_angle_from_four_points test failed");
      $finish;
    end
  end

  function automatic wide_t wide_abs(input wide_t v);
    return v < 0 ? -v : v;
  endfunction

  function automatic int bit_length(input wide_t v);
    for (int k = 255; k >= 0; k--) if (v[k]) return k + 1;
    return 0;
  endfunction

  function automatic logic [63:0] root_of(input wide_t m);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [255:0] c2;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c  = r | (64'd1 << b);
      c2 = {192'b0, c} * {192'b0, c};
      if (c2 <= $unsigned(m)) r = c;
    end
    return r;
  endfunction

  function automatic longint to_angle(input logic [63:0] v);
    return longint'((v + (64'd1 << (31 - tafp_pkg::AngleFrac))) >> (32 - tafp_pkg::AngleFrac));
  endfunction

  // Dihedral angle of one point set, exact products then CORDIC.
  function automatic tafp_pkg::tafp_res_t torsion_of(input tafp_pkg::tafp_in_t p);
    longint              pt [4][3];
    wide_t               bv [3][3];
    wide_t               n1 [3];
    wide_t               n2 [3];
    wide_t               x, y, ax, ay;
    int                  la, sh;
    longint              xs, ys, zz, tt, dx, dy, pi_a;
    tafp_pkg::tafp_res_t r;
    pt[0] = '{longint'(p.p1_x), longint'(p.p1_y), longint'(p.p1_z)};
    pt[1] = '{longint'(p.p2_x), longint'(p.p2_y), longint'(p.p2_z)};
    pt[2] = '{longint'(p.p3_x), longint'(p.p3_y), longint'(p.p3_z)};
    pt[3] = '{longint'(p.p4_x), longint'(p.p4_y), longint'(p.p4_z)};
    for (int k = 0; k < 3; k++)
      for (int j = 0; j < 3; j++) bv[k][j] = wide_t'(pt[k+1][j] - pt[k][j]);
    n1[0] = bv[0][1] * bv[1][2] - bv[0][2] * bv[1][1];
    n1[1] = bv[0][2] * bv[1][0] - bv[0][0] * bv[1][2];
    n1[2] = bv[0][0] * bv[1][1] - bv[0][1] * bv[1][0];
    n2[0] = bv[1][1] * bv[2][2] - bv[1][2] * bv[2][1];
    n2[1] = bv[1][2] * bv[2][0] - bv[1][0] * bv[2][2];
    n2[2] = bv[1][0] * bv[2][1] - bv[1][1] * bv[2][0];
    r = '0;
    // A zero normal or a zero middle bond has no defined angle.
    if ((n1[0] == 0 && n1[1] == 0 && n1[2] == 0) ||
        (n2[0] == 0 && n2[1] == 0 && n2[2] == 0) ||
        (bv[1][0] == 0 && bv[1][1] == 0 && bv[1][2] == 0)) begin
      r.degenerate = 1'b1;
      return r;
    end
    x = (n1[0] * n2[0] + n1[1] * n2[1] + n1[2] * n2[2]) <<< tafp_pkg::SqrtGuard;
    y = (bv[0][0] * n2[0] + bv[0][1] * n2[1] + bv[0][2] * n2[2]) *
        wide_t'({192'b0, root_of((bv[1][0] * bv[1][0] + bv[1][1] * bv[1][1] +
                                  bv[1][2] * bv[1][2]) <<< (2 * tafp_pkg::SqrtGuard))});
    // Bring the larger magnitude down to the CORDIC input width.
    ax = wide_abs(x);
    ay = wide_abs(y);
    la = bit_length(ax);
    if (bit_length(ay) > la) la = bit_length(ay);
    sh = la > tafp_pkg::CordicInBits ? la - tafp_pkg::CordicInBits : 0;
    xs = longint'(ax >> sh);
    ys = longint'(ay >> sh);
    if (x < 0) xs = -xs;
    if (y < 0) ys = -ys;
    zz = 0;
    // Left half plane: turn by a quarter first.
    if (xs < 0) begin
      if (ys >= 0) begin
        tt = xs; xs = ys; ys = -tt; zz = to_angle(tafp_pkg::HalfPiQ32);
      end else begin
        tt = xs; xs = -ys; ys = tt; zz = -to_angle(tafp_pkg::HalfPiQ32);
      end
    end
    for (int i = 0; i < tafp_pkg::CordicStages; i++) begin
      dx = ys >>> i;
      dy = xs >>> i;
      if (ys >= 0) begin
        xs += dx; ys -= dy; zz += to_angle(tafp_pkg::AtanQ32[i]);
      end else begin
        xs -= dx; ys += dy; zz -= to_angle(tafp_pkg::AtanQ32[i]);
      end
    end
    pi_a = to_angle(tafp_pkg::PiQ32);
    if (zz > pi_a) zz = pi_a;
    if (zz < -pi_a) zz = -pi_a;
    r.torsion = zz[tafp_pkg::TorsionW-1:0];
    return r;
  endfunction

  // Result checker: every strobe takes the oldest expected angle.
  always @(posedge clk_i) begin
    tafp_pkg::tafp_res_t want;
    if (rst_ni && done_o) begin
      if (angle_q.size() == 0) begin
        $display("%0t: unexpected result torsion=%0d degenerate=%0b", $time,
                 res_o.torsion, res_o.degenerate);
        errors++;
      end else begin
        want = angle_q.pop_front();
        if (res_o.torsion !== want.torsion) begin
          $display("%0t: torsion expected %0d actual %0d", $time, want.torsion,
                   res_o.torsion);
          errors++;
        end
        if (res_o.degenerate !== want.degenerate) begin
          $display("%0t: degenerate expected %0b actual %0b", $time,
                   want.degenerate, res_o.degenerate);
          errors++;
        end
      end
    end
  end

  // Presents one item and records its expected angle when it is taken.
  task automatic send_points(input tafp_pkg::tafp_in_t p, input bit known,
                             input tafp_pkg::tafp_res_t want);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 :
          ($urandom_range(0, 9) == 0 ? $urandom_range(5, 30) : $urandom_range(0, 2));
    if (gap > 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    pts_i   <= p;
    do @(posedge clk_i); while (busy_o);
    angle_q.push_back(known ? want : torsion_of(p));
  endtask

  function automatic logic signed [tafp_pkg::CoordW-1:0] rand_coord(input int span);
    if (span >= tafp_pkg::CoordW) return tafp_pkg::CoordW'($urandom());
    return tafp_pkg::CoordW'($signed($urandom_range(0, (1 << span) - 1))
                             - (1 << (span - 1)));
  endfunction

  typedef struct {
    tafp_pkg::tafp_in_t  pts;
    bit                  known;
    tafp_pkg::tafp_res_t want;
  } row_t;

  localparam logic signed [tafp_pkg::CoordW-1:0] CMax = 24'sh7FFFFF;
  localparam logic signed [tafp_pkg::CoordW-1:0] CMin = 24'sh800000;
  localparam logic signed [tafp_pkg::CoordW-1:0] One  = 24'sh001000;

  row_t                rows [$];
  tafp_pkg::tafp_in_t  p;
  tafp_pkg::tafp_res_t deg_res;
  int                  mode;
  int                  span;

  initial begin
    errors  = 0;
    cycles  = 0;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    pts_i   = '0;
    deg_res = '{torsion: '0, degenerate: 1'b1};

    // Directed set: degenerate shapes carry their known answer.
    rows.push_back('{'0, 1, deg_res});
    rows.push_back('{'{One, 0, 0, 0, 0, 0, 0, 0, 0, 0, One, 0}, 1, deg_res});
    rows.push_back('{'{0, 0, 0, One, 0, 0, 2*One, 0, 0, 0, One, 0}, 1, deg_res});
    rows.push_back('{'{0, One, 0, 0, 0, 0, One, 0, 0, 3*One, 0, 0}, 1, deg_res});
    rows.push_back('{'{CMin, CMin, CMin, CMax, CMax, CMax, CMax, CMax, CMax,
                       0, 0, 0}, 1, deg_res});
    // Cis, trans, both right angles and two near-trans shapes.
    rows.push_back('{'{0, One, 0, 0, 0, 0, One, 0, 0, One, One, 0}, 0, '0});
    rows.push_back('{'{0, One, 0, 0, 0, 0, One, 0, 0, One, -One, 0}, 0, '0});
    rows.push_back('{'{0, One, 0, 0, 0, 0, One, 0, 0, One, 0, One}, 0, '0});
    rows.push_back('{'{0, One, 0, 0, 0, 0, One, 0, 0, One, 0, -One}, 0, '0});
    rows.push_back('{'{0, One, 0, 0, 0, 0, One, 0, 0, One, -One, 1}, 0, '0});
    rows.push_back('{'{0, One, 0, 0, 0, 0, One, 0, 0, One, -One, -1}, 0, '0});
    // Coordinate extremes and tiny coordinates.
    rows.push_back('{'{CMax, CMin, CMax, CMin, CMax, CMin, CMax, CMax, CMin,
                       CMin, CMin, CMax}, 0, '0});
    rows.push_back('{'{CMin, CMin, CMin, CMax, CMin, CMin, CMax, CMax, CMin,
                       CMax, CMax, CMax}, 0, '0});
    rows.push_back('{'{CMax, 0, CMin, 0, CMax, 0, CMin, 0, CMax, 1, -1, 1}, 0, '0});
    rows.push_back('{'{1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 1, 1}, 0, '0});
    rows.push_back('{'{-1, -1, -1, 0, 0, 0, 1, 0, 0, 1, 1, 0}, 0, '0});

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i]) send_points(rows[i].pts, rows[i].known, rows[i].want);

    // Random part: mostly nearby points, some full range, some degenerate.
    for (int n = 0; n < RandItems; n++) begin
      mode = $urandom_range(0, 9);
      span = (mode < 3) ? tafp_pkg::CoordW : $urandom_range(2, 20);
      for (int k = 0; k < 12; k++) begin
        p[k*tafp_pkg::CoordW +: tafp_pkg::CoordW] = rand_coord(span);
      end
      if (mode == 9) begin
        case ($urandom_range(0, 2))
          0: begin p.p3_x = p.p2_x; p.p3_y = p.p2_y; p.p3_z = p.p2_z; end
          1: begin
            p.p1_x = p.p2_x - (p.p3_x - p.p2_x);
            p.p1_y = p.p2_y - (p.p3_y - p.p2_y);
            p.p1_z = p.p2_z - (p.p3_z - p.p2_z);
          end
          default: begin p.p4_x = p.p3_x; p.p4_y = p.p3_y; p.p4_z = p.p3_z; end
        endcase
      end
      send_points(p, 0, '0);
    end

    @(negedge clk_i);
    start_i <= 1'b0;
    wait (angle_q.size() == 0);
    repeat (80) @(posedge clk_i);
    if (errors == 0) begin
      $display("torsion_angle_from_four_points test passed");
    end else begin
      $display("torsion_angle_from_four_points test failed");
    end
    $finish;
  end
endmodule
